### rtl/sic_pkg.sv
`timescale 1ns / 1ps

package sic_pkg;

   // Result codes on the relation field
   typedef enum logic [2:0] {
      REL_NONE        = 3'd0,
      REL_CROSS       = 3'd1,
      REL_TOUCH_START = 3'd2,
      REL_TOUCH_END   = 3'd3,
      REL_OVERLAP     = 3'd4
   } rel_type;

   // Endpoint coincidence flags, taken from the raw coordinates
   typedef struct packed {
      logic a_pt;    // segment A is a single point
      logic a1_b1;
      logic a2_b2;
      logic a1_b2;
      logic a2_b1;
   } sic_eq_type;

   // Sign and zero flags of the orientation and betweenness sums
   typedef struct packed {
      logic [3:0] c_zero;
      logic [3:0] c_neg;
      logic       e1_ge;
      logic       e2_ge;
      logic       s3_zero;
      logic       s3_ge;
      logic       s4_zero;
      logic       s4_ge;
   } sic_sign_type;

endpackage

### rtl/sic_classify.sv
`timescale 1ns / 1ps

module sic_classify (
   input  sic_pkg::sic_eq_type   eq,
   input  sic_pkg::sic_sign_type sg,
   output sic_pkg::rel_type      relation
);
   import sic_pkg::*;

   logic collinear;
   logic ident;
   logic ends_in;
   logic straddle_a;
   logic straddle_b;

   // Decide collinearity and identical segments
   assign collinear = &sg.c_zero;
   assign ident     = !eq.a_pt && ((eq.a1_b1 && eq.a2_b2) || (eq.a1_b2 && eq.a2_b1));
   assign ends_in   = sg.e1_ge && sg.e2_ge;

   // Each pair of orientations must not lie strictly on one side
   assign straddle_a = !(!sg.c_zero[0] && !sg.c_zero[1] && (sg.c_neg[0] == sg.c_neg[1]));
   assign straddle_b = !(!sg.c_zero[2] && !sg.c_zero[3] && (sg.c_neg[2] == sg.c_neg[3]));

   // Pick the relation code
   always_comb begin
      relation = REL_NONE;
      if (collinear) begin
         if (ident) begin
            relation = REL_OVERLAP;
         end else if (ends_in && sg.s3_zero && sg.s4_ge) begin
            relation = REL_TOUCH_START;
         end else if (ends_in && sg.s3_ge && sg.s4_zero) begin
            relation = REL_TOUCH_END;
         end else if (ends_in && sg.s3_ge && sg.s4_ge) begin
            relation = REL_NONE;
         end else begin
            relation = REL_OVERLAP;
         end
      end else if (straddle_a && straddle_b) begin
         relation = REL_CROSS;
      end
   end

endmodule

### rtl/segment_intersection_classifier.sv
`timescale 1ns / 1ps

// Segment intersection classifier.
// The req_ channel carries one pair of integer segments per transaction:
// A from (a_start_x, a_start_y) to (a_end_x, a_end_y), B likewise. The rsp_
// channel returns one transaction per pair: the relation code, the touching
// endpoint of A for a collinear single-point touch, and for a crossing the
// parameter along A as the exact fraction frac_num / frac_den (sign of the
// denominator not normalised).
// Both channels use valid/ready. The datapath is a four-stage pipeline:
// differences, products, sums, then classification into the output register.
// Throughput is one pair per cycle, limited only by the output handshake.
// Each stage has its own valid bit and loads when it is empty or the next
// stage moves, so req_ready stays high while bubbles remain even if the
// receiver stalls; a full pipeline with rsp_ready low holds every stage.
// Synchronous reset empties all stages; no state survives between pairs.
module segment_intersection_classifier #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_WIDTH-1:0]     req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0]     req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0]     req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0]     req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0]     req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0]     req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0]     req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0]     req_b_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sic_pkg::rel_type                  rsp_relation,
   output logic signed [COORD_WIDTH-1:0]     rsp_touch_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_touch_y,
   output logic signed [2*COORD_WIDTH+1:0]   rsp_frac_num,
   output logic signed [2*COORD_WIDTH+1:0]   rsp_frac_den
);
   import sic_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH + 2;
   localparam int SW = PW + 1;
   localparam int FW = 2 * COORD_WIDTH + 2;

   // Stage valid bits and load enables
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: differences
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff;
   logic signed [DW-1:0] u1x_ff, u1y_ff, u2x_ff, u2y_ff;
   logic signed [DW-1:0] u3x_ff, u3y_ff, u4x_ff, u4y_ff;
   logic signed [COORD_WIDTH-1:0] a1x_s1_ff, a1y_s1_ff, a2x_s1_ff, a2y_s1_ff;
   sic_eq_type eq_in, eq_s1_ff;

   // Stage 2: products
   logic signed [PW-1:0] pa_ff [8];
   logic signed [PW-1:0] pb_ff [8];
   logic signed [COORD_WIDTH-1:0] a1x_s2_ff, a1y_s2_ff, a2x_s2_ff, a2y_s2_ff;
   sic_eq_type eq_s2_ff;

   // Stage 3: sums
   logic signed [SW-1:0] sum_ff [8];
   logic signed [COORD_WIDTH-1:0] a1x_s3_ff, a1y_s3_ff, a2x_s3_ff, a2y_s3_ff;
   sic_eq_type eq_s3_ff;

   // Stage 4: classification and output register
   sic_sign_type sg;
   rel_type relation_in, relation_ff;
   logic signed [SW:0] den_full;
   logic signed [COORD_WIDTH-1:0] touch_x_in, touch_y_in, touch_x_ff, touch_y_ff;
   logic signed [FW-1:0] num_in, den_in, num_ff, den_ff;

   // Ready chain: a stage loads when empty or when its successor moves
   assign rdy4      = !out_v_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff    <= req_valid;
         if (rdy2) v2_ff    <= v1_ff;
         if (rdy3) v3_ff    <= v2_ff;
         if (rdy4) out_v_ff <= v3_ff;
      end
   end

   // Compare endpoints for the identical-segment test
   assign eq_in.a_pt  = (req_a_start_x == req_a_end_x) && (req_a_start_y == req_a_end_y);
   assign eq_in.a1_b1 = (req_a_start_x == req_b_start_x) && (req_a_start_y == req_b_start_y);
   assign eq_in.a2_b2 = (req_a_end_x == req_b_end_x) && (req_a_end_y == req_b_end_y);
   assign eq_in.a1_b2 = (req_a_start_x == req_b_end_x) && (req_a_start_y == req_b_end_y);
   assign eq_in.a2_b1 = (req_a_end_x == req_b_start_x) && (req_a_end_y == req_b_start_y);

   // Stage 1: take the coordinate differences
   always_ff @(posedge clock) begin
      if (rdy1) begin
         dax_ff    <= DW'(req_a_end_x) - DW'(req_a_start_x);
         day_ff    <= DW'(req_a_end_y) - DW'(req_a_start_y);
         dbx_ff    <= DW'(req_b_end_x) - DW'(req_b_start_x);
         dby_ff    <= DW'(req_b_end_y) - DW'(req_b_start_y);
         u1x_ff    <= DW'(req_a_start_x) - DW'(req_b_start_x);
         u1y_ff    <= DW'(req_a_start_y) - DW'(req_b_start_y);
         u2x_ff    <= DW'(req_a_end_x) - DW'(req_b_start_x);
         u2y_ff    <= DW'(req_a_end_y) - DW'(req_b_start_y);
         u3x_ff    <= DW'(req_a_start_x) - DW'(req_b_end_x);
         u3y_ff    <= DW'(req_a_start_y) - DW'(req_b_end_y);
         u4x_ff    <= DW'(req_a_end_x) - DW'(req_b_end_x);
         u4y_ff    <= DW'(req_a_end_y) - DW'(req_b_end_y);
         a1x_s1_ff <= req_a_start_x;
         a1y_s1_ff <= req_a_start_y;
         a2x_s1_ff <= req_a_end_x;
         a2y_s1_ff <= req_a_end_y;
         eq_s1_ff  <= eq_in;
      end
   end

   // Stage 2: form the products; the first four pairs are cross terms,
   // the last four are dot terms
   always_ff @(posedge clock) begin
      if (rdy2) begin
         pa_ff[0]  <= u1x_ff * day_ff;  pb_ff[0] <= u1y_ff * dax_ff;
         pa_ff[1]  <= u3x_ff * day_ff;  pb_ff[1] <= u3y_ff * dax_ff;
         pa_ff[2]  <= dbx_ff * u1y_ff;  pb_ff[2] <= dby_ff * u1x_ff;
         pa_ff[3]  <= dbx_ff * u2y_ff;  pb_ff[3] <= dby_ff * u2x_ff;
         pa_ff[4]  <= u1x_ff * u2x_ff;  pb_ff[4] <= u1y_ff * u2y_ff;
         pa_ff[5]  <= u3x_ff * u4x_ff;  pb_ff[5] <= u3y_ff * u4y_ff;
         pa_ff[6]  <= u1x_ff * u3x_ff;  pb_ff[6] <= u1y_ff * u3y_ff;
         pa_ff[7]  <= u2x_ff * u4x_ff;  pb_ff[7] <= u2y_ff * u4y_ff;
         a1x_s2_ff <= a1x_s1_ff;
         a1y_s2_ff <= a1y_s1_ff;
         a2x_s2_ff <= a2x_s1_ff;
         a2y_s2_ff <= a2y_s1_ff;
         eq_s2_ff  <= eq_s1_ff;
      end
   end

   // Stage 3: subtract cross terms, add dot terms
   always_ff @(posedge clock) begin
      if (rdy3) begin
         for (int k = 0; k < 8; k++) begin
            if (k < 4) begin
               sum_ff[k] <= SW'(pa_ff[k]) - SW'(pb_ff[k]);
            end else begin
               sum_ff[k] <= SW'(pa_ff[k]) + SW'(pb_ff[k]);
            end
         end
         a1x_s3_ff <= a1x_s2_ff;
         a1y_s3_ff <= a1y_s2_ff;
         a2x_s3_ff <= a2x_s2_ff;
         a2y_s3_ff <= a2y_s2_ff;
         eq_s3_ff  <= eq_s2_ff;
      end
   end

   // Stage 4: reduce sums to sign and zero flags
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sg.c_zero[k] = (sum_ff[k] == '0);
         sg.c_neg[k]  = sum_ff[k][SW-1];
      end
      sg.e1_ge   = !sum_ff[4][SW-1];
      sg.e2_ge   = !sum_ff[5][SW-1];
      sg.s3_zero = (sum_ff[6] == '0);
      sg.s3_ge   = !sum_ff[6][SW-1];
      sg.s4_zero = (sum_ff[7] == '0);
      sg.s4_ge   = !sum_ff[7][SW-1];
   end

   sic_classify u_classify (
      .eq       (eq_s3_ff),
      .sg       (sg),
      .relation (relation_in)
   );

   // Numerator is the third orientation; denominator is its difference with the fourth
   assign den_full = (SW + 1)'(sum_ff[2]) - (SW + 1)'(sum_ff[3]);

   // Select the payload that goes with the relation
   always_comb begin
      touch_x_in = '0;
      touch_y_in = '0;
      num_in     = '0;
      den_in     = '0;
      case (relation_in)
         REL_TOUCH_START: begin
            touch_x_in = a1x_s3_ff;
            touch_y_in = a1y_s3_ff;
         end
         REL_TOUCH_END: begin
            touch_x_in = a2x_s3_ff;
            touch_y_in = a2y_s3_ff;
         end
         REL_CROSS: begin
            num_in = sum_ff[2][FW-1:0];
            den_in = den_full[FW-1:0];
         end
         default: begin
            touch_x_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         relation_ff <= relation_in;
         touch_x_ff  <= touch_x_in;
         touch_y_ff  <= touch_y_in;
         num_ff      <= num_in;
         den_ff      <= den_in;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_relation = relation_ff;
   assign rsp_touch_x  = touch_x_ff;
   assign rsp_touch_y  = touch_y_ff;
   assign rsp_frac_num = num_ff;
   assign rsp_frac_den = den_ff;

   // Fraction is zero unless the segments cross
   a_frac_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_relation != REL_CROSS) |-> (rsp_frac_num == '0) && (rsp_frac_den == '0))
      else $error("fraction not cleared for a non-crossing result");

   // A crossing never has a zero denominator
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_relation == REL_CROSS) |-> (rsp_frac_den != '0))
      else $error("crossing result with zero denominator");

   // Touch point is zero unless the relation is a single-endpoint touch
   a_touch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_relation != REL_TOUCH_START) && (rsp_relation != REL_TOUCH_END)
      |-> (rsp_touch_x == '0) && (rsp_touch_y == '0))
      else $error("touch point not cleared");

   // An item in the last stage reaches an empty output register at once
   a_advance: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !out_v_ff |=> rsp_valid)
      else $error("pipeline failed to advance into the output register");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v2_ff && !v3_ff)
      else $error("pipeline not empty after reset");

endmodule
